FILE: sv/fwrv_pkg.sv
// ----------------------------------------------------------------------------
// fwrv_pkg
// Shared types, codes and the CRC-32 byte update for the firmware image
// receiver.
// ----------------------------------------------------------------------------
package fwrv_pkg;

    localparam int unsigned CHUNK_BYTES     = 2048;
    localparam int unsigned CHUNK_LOG2      = $clog2(CHUNK_BYTES);
    localparam int unsigned MAX_IMAGE_BYTES = 16777216;

    localparam int unsigned SIZE_W  = 25;
    localparam int unsigned ADDR_W  = 24;
    localparam int unsigned CRC_W   = 32;
    localparam int unsigned TOUT_W  = 16;
    localparam int unsigned APB_AW  = 4;

    localparam logic [CRC_W-1:0]  CRC_POLY    = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]  CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [TOUT_W-1:0] TOUT_RESET  = 16'd3000;
    localparam logic [SIZE_W-1:0] MAX_SIZE    = SIZE_W'(MAX_IMAGE_BYTES);

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [2:0] EV_WRITE    = 3'd0;
    localparam logic [2:0] EV_ACK      = 3'd1;
    localparam logic [2:0] EV_DONE     = 3'd2;
    localparam logic [2:0] EV_MISMATCH = 3'd3;
    localparam logic [2:0] EV_TIMEOUT  = 3'd4;
    localparam logic [2:0] EV_BADSIZE  = 3'd5;

    localparam logic [1:0] REG_IMAGE_SIZE   = 2'd0;
    localparam logic [1:0] REG_EXPECTED_CRC = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_MS   = 2'd2;

    localparam logic PH_IDLE = 1'b0;
    localparam logic PH_RECV = 1'b1;

    typedef struct packed {
        logic [2:0]        event_res;
        logic [ADDR_W-1:0] flash_address;
        logic [7:0]        write_byte;
        logic [SIZE_W-1:0] byte_count;
        logic [CRC_W-1:0]  crc_value;
        logic              last;
    } t_res;

    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
        end
        return c;
    endfunction

endpackage

FILE: sv/fwrv_in_if.sv
// ----------------------------------------------------------------------------
// fwrv_in_if
// Input word channel: opcode and received byte, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fwrv_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

FILE: sv/fwrv_out_if.sv
// ----------------------------------------------------------------------------
// fwrv_out_if
// Result word channel: event code and its fields, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fwrv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [23:0] flash_address;
    logic [7:0]  write_byte;
    logic [24:0] byte_count;
    logic [31:0] crc_value;
    logic        last;

    modport source (output valid, output event_res, output flash_address,
                    output write_byte, output byte_count, output crc_value,
                    output last, input ready);
    modport sink   (input valid, input event_res, input flash_address,
                    input write_byte, input byte_count, input crc_value,
                    input last, output ready);
endinterface

FILE: sv/firmware_image_receive_verify_top.sv
// ----------------------------------------------------------------------------
// firmware_image_receive_verify_top
// Chunked image receiver: flash writes, chunk acks, CRC-32 check, timeout.
// ----------------------------------------------------------------------------
// The first result word of an input word is registered and appears in the
// cycle after the input word is accepted.
// One input word per cycle while each word gives at most one result and the
// output is taken; a word with more results holds input off until the three-entry result queue drains.
// Reset: synchronous, active low; idle phase, CRC all ones, timeout 3000.
// ----------------------------------------------------------------------------
module firmware_image_receive_verify_top
    import fwrv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    fwrv_in_if.sink           i_in,
    fwrv_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [SIZE_W-1:0] r_image_size;
    logic [CRC_W-1:0]  r_expected_crc;
    logic [TOUT_W-1:0] r_timeout_ms;

    logic              r_phase, n_phase;
    logic [SIZE_W-1:0] r_total, n_total;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [TOUT_W-1:0] r_idle, n_idle;

    t_res       r_slot [3];
    t_res       n_slot [3];
    logic [1:0] r_cnt, n_cnt;

    logic              in_take;
    logic              out_take;
    logic              cfg_wr;
    logic [1:0]        cfg_idx;
    logic [SIZE_W-1:0] inc_total;
    logic [CRC_W-1:0]  folded;
    logic              end_hit;
    logic              ack_hit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_AW-1:2];

    always_comb begin
        case (cfg_idx)
            REG_IMAGE_SIZE:   prdata = {7'd0, r_image_size};
            REG_EXPECTED_CRC: prdata = r_expected_crc;
            REG_TIMEOUT_MS:   prdata = {16'd0, r_timeout_ms};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size   <= '0;
            r_expected_crc <= '0;
            r_timeout_ms   <= TOUT_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_IMAGE_SIZE:   r_image_size   <= pwdata[SIZE_W-1:0];
                REG_EXPECTED_CRC: r_expected_crc <= pwdata;
                REG_TIMEOUT_MS:   r_timeout_ms   <= pwdata[TOUT_W-1:0];
                default:          ;
            endcase
        end
    end

    assign out_take    = o_out.valid && o_out.ready;
    assign i_in.ready  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_take);
    assign in_take     = i_in.valid && i_in.ready;

    assign inc_total = r_total + SIZE_W'(1);
    assign folded    = crc_fold(r_crc, i_in.data_byte);
    assign end_hit   = (inc_total >= r_image_size) || (inc_total >= MAX_SIZE);
    assign ack_hit   = end_hit || (inc_total[CHUNK_LOG2-1:0] == '0);

    always_comb begin
        n_phase = r_phase;
        n_total = r_total;
        n_crc   = r_crc;
        n_idle  = r_idle;
        n_cnt   = 2'd0;
        for (int s = 0; s < 3; s++) begin
            n_slot[s] = '0;
        end
        case (i_in.opcode)
            OP_START: begin
                if ((r_image_size == '0) || (r_image_size > MAX_SIZE)) begin
                    n_phase             = PH_IDLE;
                    n_slot[0].event_res = EV_BADSIZE;
                    n_slot[0].last      = 1'b1;
                    n_cnt               = 2'd1;
                end else begin
                    n_phase = PH_RECV;
                    n_total = '0;
                    n_crc   = CRC_INIT;
                    n_idle  = '0;
                end
            end
            OP_BYTE: begin
                if (r_phase == PH_RECV) begin
                    n_slot[0].event_res     = EV_WRITE;
                    n_slot[0].flash_address = r_total[ADDR_W-1:0];
                    n_slot[0].write_byte    = i_in.data_byte;
                    n_slot[0].last          = !ack_hit;
                    n_cnt                   = 2'd1;
                    n_crc                   = folded;
                    n_total                 = inc_total;
                    n_idle                  = '0;
                    if (ack_hit) begin
                        n_slot[1].event_res  = EV_ACK;
                        n_slot[1].byte_count = inc_total;
                        n_slot[1].last       = !end_hit;
                        n_cnt                = 2'd2;
                    end
                    if (end_hit) begin
                        n_slot[2].event_res  = ((folded ^ CRC_INIT) == r_expected_crc)
                                               ? EV_DONE : EV_MISMATCH;
                        n_slot[2].byte_count = inc_total;
                        n_slot[2].crc_value  = folded ^ CRC_INIT;
                        n_slot[2].last       = 1'b1;
                        n_cnt                = 2'd3;
                        n_phase              = PH_IDLE;
                    end
                end
            end
            OP_TICK: begin
                if (r_phase == PH_RECV) begin
                    if (r_idle >= r_timeout_ms) begin
                        n_slot[0].event_res  = EV_TIMEOUT;
                        n_slot[0].byte_count = r_total;
                        n_slot[0].last       = 1'b1;
                        n_cnt                = 2'd1;
                        n_phase              = PH_IDLE;
                    end else begin
                        n_idle = r_idle + TOUT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_total <= '0;
            r_crc   <= CRC_INIT;
            r_idle  <= '0;
        end else if (in_take) begin
            r_phase <= n_phase;
            r_total <= n_total;
            r_crc   <= n_crc;
            r_idle  <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (in_take) begin
            r_cnt <= n_cnt;
        end else if (out_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_slot <= n_slot;
        end else if (out_take) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    assign o_out.valid         = (r_cnt != 2'd0);
    assign o_out.event_res     = r_slot[0].event_res;
    assign o_out.flash_address = r_slot[0].flash_address;
    assign o_out.write_byte    = r_slot[0].write_byte;
    assign o_out.byte_count    = r_slot[0].byte_count;
    assign o_out.crc_value     = r_slot[0].crc_value;
    assign o_out.last          = r_slot[0].last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_take && (r_cnt >= 2'd2)))
        else $error("input word accepted while result queue busy");

    a_last_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_cnt == 2'd1) |-> o_out.last)
        else $error("final queued result lacks last");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.event_res == EV_DONE || o_out.event_res == EV_MISMATCH ||
         o_out.event_res == EV_TIMEOUT || o_out.event_res == EV_BADSIZE))
        |-> r_phase == PH_IDLE)
        else $error("transfer still open after a closing event");

    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_in.opcode == OP_BYTE && r_phase == PH_IDLE) |=> r_cnt == 2'd0)
        else $error("byte outside a transfer produced a result");

    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= MAX_SIZE)
        else $error("byte total beyond maximum image size");

endmodule

FILE: tb/fwrv_image_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fwrv_image_checker
// Watches the register port and both word channels of the image receiver,
// predicts every result word from its own copy of the receive state and
// scores the words that come out, field by field, in order.
// ----------------------------------------------------------------------------
module fwrv_image_checker
    import fwrv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [1:0]        i_in_opcode,
    input  logic [7:0]        i_in_data_byte,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_res              i_out_word,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output int                o_fail_count,
    output int                o_pending
);

    logic [SIZE_W-1:0] cfg_image_size;
    logic [CRC_W-1:0]  cfg_expected_crc;
    logic [TOUT_W-1:0] cfg_timeout_ms;

    logic              receiving;
    logic [SIZE_W-1:0] bytes_seen;
    logic [CRC_W-1:0]  crc_acc;
    logic [TOUT_W-1:0] ticks_idle;

    t_res expected_words[$];
    int   fail_total = 0;

    function automatic logic [CRC_W-1:0] crc32_shift_byte(input logic [CRC_W-1:0] crc,
                                                          input logic [7:0] data);
        logic [CRC_W-1:0] c;
        logic             feedback;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            feedback = c[0] ^ data[i];
            c = c >> 1;
            if (feedback) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic t_res event_word(input logic [2:0] ev, input logic [ADDR_W-1:0] addr,
                                        input logic [7:0] data, input logic [SIZE_W-1:0] count,
                                        input logic [CRC_W-1:0] crc);
        t_res w;
        w.event_res     = ev;
        w.flash_address = addr;
        w.write_byte    = data;
        w.byte_count    = count;
        w.crc_value     = crc;
        w.last          = 1'b0;
        return w;
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic predict_word(input logic [1:0] op, input logic [7:0] db);
        t_res             produced[$];
        t_res             tail;
        logic             finished;
        logic [CRC_W-1:0] final_crc;
        case (op)
            OP_START: begin
                if (cfg_image_size == '0 || cfg_image_size > MAX_SIZE) begin
                    receiving = PH_IDLE;
                    produced.push_back(event_word(EV_BADSIZE, '0, '0, '0, '0));
                end else begin
                    receiving  = PH_RECV;
                    bytes_seen = '0;
                    crc_acc    = CRC_INIT;
                    ticks_idle = '0;
                end
            end
            OP_BYTE: begin
                if (receiving == PH_RECV) begin
                    produced.push_back(event_word(EV_WRITE, bytes_seen[ADDR_W-1:0], db,
                                                  '0, '0));
                    crc_acc    = crc32_shift_byte(crc_acc, db);
                    bytes_seen = bytes_seen + 1'b1;
                    ticks_idle = '0;
                    finished   = (bytes_seen >= cfg_image_size) || (bytes_seen >= MAX_SIZE);
                    if (finished || bytes_seen[CHUNK_LOG2-1:0] == '0) begin
                        produced.push_back(event_word(EV_ACK, '0, '0, bytes_seen, '0));
                    end
                    if (finished) begin
                        final_crc = ~crc_acc;
                        produced.push_back(event_word(
                            (final_crc == cfg_expected_crc) ? EV_DONE : EV_MISMATCH,
                            '0, '0, bytes_seen, final_crc));
                        receiving = PH_IDLE;
                    end
                end
            end
            OP_TICK: begin
                if (receiving == PH_RECV) begin
                    if (ticks_idle >= cfg_timeout_ms) begin
                        produced.push_back(event_word(EV_TIMEOUT, '0, '0, bytes_seen, '0));
                        receiving = PH_IDLE;
                    end else begin
                        ticks_idle = ticks_idle + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (produced.size() != 0) begin
            tail      = produced.pop_back();
            tail.last = 1'b1;
            produced.push_back(tail);
        end
        foreach (produced[i]) begin
            expected_words.push_back(produced[i]);
        end
    endtask

    task automatic check_word(input t_res got);
        t_res want;
        int   bad;
        if (expected_words.size() == 0) begin
            $error("unexpected result word: event_res %0d", got.event_res);
            fail_total++;
        end else begin
            want = expected_words.pop_front();
            bad  = field_differs("event_res", 32'(want.event_res), 32'(got.event_res))
                 + field_differs("flash_address", 32'(want.flash_address),
                                 32'(got.flash_address))
                 + field_differs("write_byte", 32'(want.write_byte), 32'(got.write_byte))
                 + field_differs("byte_count", 32'(want.byte_count), 32'(got.byte_count))
                 + field_differs("crc_value", want.crc_value, got.crc_value)
                 + field_differs("last", 32'(want.last), 32'(got.last));
            fail_total += bad;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_image_size   = '0;
            cfg_expected_crc = '0;
            cfg_timeout_ms   = TOUT_RESET;
            receiving        = PH_IDLE;
            bytes_seen       = '0;
            crc_acc          = CRC_INIT;
            ticks_idle       = '0;
            expected_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_word(i_out_word);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_AW-1:2])
                    REG_IMAGE_SIZE:   cfg_image_size   = i_pwdata[SIZE_W-1:0];
                    REG_EXPECTED_CRC: cfg_expected_crc = i_pwdata;
                    REG_TIMEOUT_MS:   cfg_timeout_ms   = i_pwdata[TOUT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_word(i_in_opcode, i_in_data_byte);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_words.size();
    end

endmodule

FILE: tb/tb_firmware_image_receive_verify_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_firmware_image_receive_verify_top
// Feeds the image receiver start, byte and tick words and register writes:
// a directed pass over bad sizes, timeouts, restarts and CRC outcomes, then
// random transfers under four send/stall mixes. Scoring is in the checker.
// ----------------------------------------------------------------------------
module tb_firmware_image_receive_verify_top;
    import fwrv_pkg::*;

    typedef enum int unsigned {
        TX_CLEAN,
        TX_TIMEOUT,
        TX_RESTART,
        TX_NOISE,
        TX_BAD_SIZE
    } t_tx_kind;

    localparam logic [1:0]  OP_UNUSED           = 2'd3;
    localparam int unsigned SETTLE_CYCLES       = 8;
    localparam int unsigned TRANSFERS_PER_PHASE = 4;
    localparam int unsigned SEND_GAP_PCT [4]    = '{0, 45, 0, 14};
    localparam int unsigned STALL_PCT [4]       = '{0, 0, 45, 14};

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              rx_ready = 1'b0;

    int unsigned send_gap_pct = 0;
    int unsigned stall_pct    = 0;
    int          fail_count;
    int          pending_count;
    logic [7:0]  image_bytes[$];

    fwrv_in_if  in_ch ();
    fwrv_out_if out_ch ();

    assign out_ch.ready = rx_ready;

    firmware_image_receive_verify_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fwrv_image_checker image_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_ch.valid),
        .i_in_ready     (in_ch.ready),
        .i_in_opcode    (in_ch.opcode),
        .i_in_data_byte (in_ch.data_byte),
        .i_out_valid    (out_ch.valid),
        .i_out_ready    (out_ch.ready),
        .i_out_word     ({out_ch.event_res, out_ch.flash_address, out_ch.write_byte,
                          out_ch.byte_count, out_ch.crc_value, out_ch.last}),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_500_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        rx_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic logic [31:0] image_crc(input logic [7:0] bytes[$]);
        logic [31:0] c;
        c = CRC_INIT;
        foreach (bytes[i]) begin
            c = c ^ {24'd0, bytes[i]};
            repeat (8) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
        end
        return ~c;
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [7:0] db);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.data_byte <= db;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // hold until every expected word is back, then let the pipe drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [SIZE_W-1:0] size, input logic [31:0] crc,
                             input logic [TOUT_W-1:0] tout);
        settle();
        apb_write(REG_IMAGE_SIZE, 32'(size));
        apb_write(REG_EXPECTED_CRC, crc);
        apb_write(REG_TIMEOUT_MS, 32'(tout));
    endtask

    // interleave ticks but never send the tick that would fire the timeout
    task automatic send_bytes(input int unsigned count, input logic [TOUT_W-1:0] tout);
        int unsigned run;
        run = 0;
        for (int unsigned i = 0; i < count; i++) begin
            while (run < 32'(tout) && $urandom_range(0, 3) == 0) begin
                send_word(OP_TICK, 8'($urandom));
                run++;
            end
            send_word(OP_BYTE, image_bytes[i]);
            run = 0;
        end
    endtask

    task automatic run_transfer(input int unsigned forced_size);
        int unsigned       pick;
        int unsigned       sz;
        int unsigned       cut;
        t_tx_kind          kind;
        logic [TOUT_W-1:0] tout;
        logic [31:0]       crc_word;
        logic [SIZE_W-1:0] bad_size;
        pick = $urandom_range(0, 9);
        kind = (forced_size != 0 || pick < 6) ? TX_CLEAN :
               (pick == 6) ? TX_TIMEOUT :
               (pick == 7) ? TX_RESTART :
               (pick == 8) ? TX_NOISE : TX_BAD_SIZE;
        sz   = (forced_size != 0) ? forced_size : $urandom_range(1, 12);
        if (kind == TX_TIMEOUT || $urandom_range(0, 1) == 0) begin
            tout = TOUT_W'($urandom_range(0, 3));
        end else begin
            tout = TOUT_W'($urandom_range(4, 65535));
        end
        image_bytes.delete();
        repeat (sz) image_bytes.push_back(8'($urandom));
        crc_word = ($urandom_range(0, 3) != 0) ? image_crc(image_bytes) : $urandom();
        if (kind == TX_BAD_SIZE) begin
            bad_size = ($urandom_range(0, 1) == 0) ? '0 :
                       SIZE_W'($urandom_range(MAX_IMAGE_BYTES + 1, (1 << SIZE_W) - 1));
            configure(bad_size, crc_word, tout);
        end else begin
            configure(SIZE_W'(sz), crc_word, tout);
        end
        cut = $urandom_range(0, sz - 1);
        case (kind)
            TX_CLEAN: begin
                send_word(OP_START, 8'($urandom));
                send_bytes(sz, tout);
                if ($urandom_range(0, 2) == 0) begin
                    send_word(OP_TICK, 8'($urandom));
                end
            end
            TX_TIMEOUT: begin
                send_word(OP_START, 8'($urandom));
                send_bytes(cut, tout);
                repeat (32'(tout) + 1) send_word(OP_TICK, 8'($urandom));
            end
            TX_RESTART: begin
                send_word(OP_START, 8'($urandom));
                send_bytes(cut, tout);
                send_word(OP_START, 8'($urandom));
                send_bytes(sz, tout);
            end
            TX_NOISE: begin
                repeat (6) send_word(2'($urandom_range(0, 3)), 8'($urandom));
            end
            default: begin
                send_word(OP_START, 8'($urandom));
                send_word(OP_BYTE, 8'($urandom));
            end
        endcase
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.opcode    <= OP_START;
        in_ch.data_byte <= 8'd0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= 32'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // size zero after reset, then words that the idle block drops
        send_word(OP_START, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_TICK, 8'h00);
        send_word(OP_UNUSED, 8'hA5);

        configure('1, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(OP_START, 8'hFF);
        configure(MAX_SIZE + 1'b1, 32'h0000_0000, 16'hFFFF);
        send_word(OP_START, 8'h5A);

        // zero timeout: first tick after a byte aborts
        configure(MAX_SIZE, 32'h0000_0000, 16'd0);
        send_word(OP_START, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_TICK, 8'h00);

        // restart mid-transfer, then a clean finish and ignored trailers
        image_bytes = '{8'h00, 8'hFF, 8'hA5};
        configure(SIZE_W'(3), image_crc(image_bytes), 16'd2);
        send_word(OP_START, 8'h00);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_TICK, 8'h00);
        send_word(OP_TICK, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_START, 8'hFF);
        send_bytes(3, 16'd0);
        send_word(OP_TICK, 8'hFF);
        send_word(OP_BYTE, 8'h3C);

        configure(SIZE_W'(1), 32'h0000_0000, 16'hFFFF);
        send_word(OP_START, 8'h00);
        send_word(OP_TICK, 8'h00);
        send_word(OP_BYTE, 8'h80);

        for (int p = 0; p < 4; p++) begin
            settle();
            send_gap_pct = SEND_GAP_PCT[p];
            stall_pct    = STALL_PCT[p];
            repeat (TRANSFERS_PER_PHASE) run_transfer(0);
        end

        settle();
        if (fail_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
